/* sv/pas_pkg.sv */
`default_nettype none

package pas_pkg;

  // Default operand width; results are two bits wider.
  localparam int unsigned PAS_OPERAND_WIDTH = 16;

  // Every search starts at the smallest prime.
  localparam int unsigned SMALLEST_PRIME = 2;

  // Command codes.
  localparam logic [1:0] CMD_SUM   = 2'd0;
  localparam logic [1:0] CMD_DIFF  = 2'd1;
  localparam logic [1:0] CMD_COUNT = 2'd2;

  // Status that the prime tester returns to the sequencer.
  typedef struct packed {
    logic done;
    logic is_prime;
  } pas_status_t;

endpackage

`default_nettype wire

/* sv/pas_prime_test.sv */
`default_nettype none

module pas_prime_test import pas_pkg::*; #(
  parameter int unsigned ResultWidth = PAS_OPERAND_WIDTH + 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [ResultWidth-1:0] value,
  output pas_status_t                 status
);

  // Divisor width holds one past the square root of the largest value.
  localparam int unsigned DW = (ResultWidth + 1) / 2 + 1;
  localparam int unsigned SW = 2 * DW;
  localparam int unsigned IW = $clog2(ResultWidth);

  typedef enum logic [1:0] {
    T_IDLE,
    T_CHECK,
    T_DIV,
    T_TEST
  } test_state_t;

  test_state_t       state;
  logic [DW-1:0]     divisor;
  logic [SW-1:0]     square;
  logic [DW-1:0]     remainder;
  logic [IW-1:0]     bit_idx;

  logic [DW:0]       rem_shift;
  logic [DW:0]       rem_sub;
  logic              rem_ge;
  logic [SW-1:0]     square_next;

  // Shared restoring-division step: one quotient bit per cycle.
  always_comb begin
    rem_shift   = {remainder, value[bit_idx]};
    rem_sub     = rem_shift - {1'b0, divisor};
    rem_ge      = rem_shift >= {1'b0, divisor};
    square_next = square + SW'({divisor, 1'b1});
  end

  // Sequencer over divisors 2, 3, 4, ... while divisor squared fits the value.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= T_IDLE;
      status.done     <= 1'b0;
      status.is_prime <= 1'b0;
    end else begin
      case (state)
        T_IDLE: begin
          if (start) begin
            divisor <= DW'(SMALLEST_PRIME);
            square  <= SW'(SMALLEST_PRIME * SMALLEST_PRIME);
            if (value < ResultWidth'(SMALLEST_PRIME)) begin
              status.done     <= 1'b1;
              status.is_prime <= 1'b0;
            end else begin
              status.done <= 1'b0;
              state       <= T_CHECK;
            end
          end else begin
            status.done <= 1'b0;
          end
        end
        T_CHECK: begin
          if (square > SW'(value)) begin
            status.done     <= 1'b1;
            status.is_prime <= 1'b1;
            state           <= T_IDLE;
          end else begin
            status.done <= 1'b0;
            remainder   <= '0;
            bit_idx     <= IW'(ResultWidth - 1);
            state       <= T_DIV;
          end
        end
        T_DIV: begin
          status.done <= 1'b0;
          remainder   <= rem_ge ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
          bit_idx     <= bit_idx - 1'b1;
          if (bit_idx == '0) begin
            state <= T_TEST;
          end
        end
        T_TEST: begin
          if (remainder == '0) begin
            status.done     <= 1'b1;
            status.is_prime <= 1'b0;
            state           <= T_IDLE;
          end else begin
            status.done <= 1'b0;
            divisor     <= divisor + 1'b1;
            square      <= square_next;
            state       <= T_CHECK;
          end
        end
        default: begin
          status.done <= 1'b0;
          state       <= T_IDLE;
        end
      endcase
    end
  end

  // The partial remainder always stays below the divisor.
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (state == T_TEST) |-> (remainder < divisor))
    else $error("remainder not below divisor");

  // The square register tracks the divisor exactly.
  a_square_tracks: assert property (@(posedge clk) disable iff (rst)
    (state == T_CHECK) |-> (square == SW'(divisor) * SW'(divisor)))
    else $error("square out of step with divisor");

  // Done is a single-cycle pulse.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    status.done |=> !status.done)
    else $error("done held for more than one cycle");

endmodule

`default_nettype wire

/* sv/prime_arithmetic_search_top.sv */
// Search: one word takes several trial-division searches; each candidate value c is divided
// by every divisor from 2 up to sqrt(c) until one divides it evenly.
// Throughput: one word at a time; the single shared divide step in pas_prime_test sets it.
// A finished result waits in the output register while the next word is taken.
// Reset (rst, synchronous) returns the sequencers to idle and drops out_valid.
`default_nettype none

module prime_arithmetic_search_top import pas_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = PAS_OPERAND_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 command,
  input  wire logic [OPERAND_WIDTH-1:0]   operand_a,
  input  wire logic [OPERAND_WIDTH-1:0]   operand_b,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [OPERAND_WIDTH+1:0]        result_prime
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned RW = OPERAND_WIDTH + 2;
  localparam logic [RW-1:0] ResultMax = {RW{1'b1}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_FINAL
  } phase_t;

  seq_state_t   state;
  phase_t       phase;
  logic [1:0]   cmd;
  logic [W-1:0] opb;
  logic [RW-1:0] cand;
  logic [RW-1:0] pa;
  logic [RW-1:0] result;
  logic [W-1:0] seen;
  logic [W-1:0] target;

  pas_status_t   test_status;
  logic          found;
  logic [RW-1:0] value_found;
  logic [RW-1:0] pair_sum;
  logic [RW-1:0] pair_diff;

  // Searches never start below the smallest prime.
  function automatic logic [RW-1:0] at_least_two(input logic [RW-1:0] x);
    return (x < RW'(SMALLEST_PRIME)) ? RW'(SMALLEST_PRIME) : x;
  endfunction

  pas_prime_test #(
    .ResultWidth(RW)
  ) u_test (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_LAUNCH),
    .value (cand),
    .status(test_status)
  );

  // Outcome of the candidate just tested.
  always_comb begin
    found       = test_status.is_prime && (seen == target);
    value_found = found ? cand : ResultMax;
    pair_sum    = pa + value_found;
    pair_diff   = (pa >= value_found) ? (pa - value_found) : (value_found - pa);
  end

  assign in_stall = (state != S_IDLE);

  // Command sequencer: next prime of a, then of b (sum and difference only), then the final search.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_A;
      out_valid <= 1'b0;
    end else begin
      // A taken word is dropped unless a new one replaces it in the same cycle.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd    <= command;
            opb    <= operand_b;
            seen   <= '0;
            target <= '0;
            phase  <= PH_A;
            cand   <= at_least_two(RW'(operand_a));
            if (command inside {CMD_SUM, CMD_DIFF, CMD_COUNT}) begin
              state <= S_LAUNCH;
            end else begin
              result <= '0;
              state  <= S_DONE;
            end
          end
        end
        S_LAUNCH: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (test_status.done) begin
            if (found || cand == ResultMax) begin
              seen <= '0;
              case (phase)
                PH_A: begin
                  pa <= value_found;
                  if (cmd == CMD_COUNT) begin
                    phase  <= PH_FINAL;
                    cand   <= value_found;
                    target <= opb;
                  end else begin
                    phase  <= PH_B;
                    cand   <= at_least_two(RW'(opb));
                    target <= '0;
                  end
                  state <= S_LAUNCH;
                end
                PH_B: begin
                  phase  <= PH_FINAL;
                  target <= '0;
                  cand   <= at_least_two((cmd == CMD_SUM) ? pair_sum : pair_diff);
                  state  <= S_LAUNCH;
                end
                default: begin
                  result <= value_found;
                  state  <= S_DONE;
                end
              endcase
            end else begin
              if (test_status.is_prime) begin
                seen <= seen + 1'b1;
              end
              cand  <= cand + 1'b1;
              state <= S_LAUNCH;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            result_prime <= result;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The tester reports only while the sequencer waits on it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    test_status.done |-> (state == S_WAIT))
    else $error("tester done outside wait state");

  // The prime count never runs past its target.
  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (seen <= target))
    else $error("prime count past target");

  // A search candidate is never below the smallest prime.
  a_cand_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> (cand >= RW'(SMALLEST_PRIME)))
    else $error("candidate below smallest prime");

  // A delivered word is zero only for an unused command, never one.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_prime != RW'(1)))
    else $error("result of one delivered");

endmodule

`default_nettype wire
